### src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on the next clock edge
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/idst_pkg.sv
// ----------------------------------------------------------------------------
// idst_pkg
// shared constants, codes and controller/datapath interface types for the
// id record slot table
// ----------------------------------------------------------------------------
package idst_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ID_BITS     = 27;
   localparam int SLOT_BITS   = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
   localparam int CMD_BITS    = 2;
   localparam int STATUS_BITS = 2;

   localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(TABLE_DEPTH);
   localparam logic [ID_BITS-1:0]  ID_MAX    = '1;
   localparam logic [ID_BITS-1:0]  ID_ONE    = ID_BITS'(1);

   typedef enum logic [CMD_BITS-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_FIND   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_EXHAUSTED = 2'd3
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic scan;
      logic commit;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;
      logic out_free;
   } ctl_stat_type;

endpackage

### src/idst_ctrl.sv
// ----------------------------------------------------------------------------
// idst_ctrl
// sequencer for the slot table: takes a word, runs the slot scan, then
// commits the table update and the result word
// ----------------------------------------------------------------------------
module idst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  idst_pkg::ctl_stat_type stat,
   output idst_pkg::ctl_cmd_type  ctrl
);
   import idst_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_COMMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in    = state_ff;
      ctrl.start  = 1'b0;
      ctrl.scan   = 1'b0;
      ctrl.commit = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ctrl.start = 1'b1;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            ctrl.scan = 1'b1;
            // last read data is folded in on this edge
            if (stat.scan_last) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (stat.out_free) begin
               ctrl.commit = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/idst_datapath.sv
// ----------------------------------------------------------------------------
// idst_datapath
// slot storage, scan address and read pipe, search accumulators, table
// update and the result word register
// ----------------------------------------------------------------------------
module idst_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [idst_pkg::CNT_BITS-1:0]        csr_wr_data,
   input  logic [idst_pkg::CMD_BITS-1:0]        req_cmd,
   input  logic [idst_pkg::ID_BITS-1:0]         req_id,
   input  idst_pkg::ctl_cmd_type                ctrl,
   output idst_pkg::ctl_stat_type               stat,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [idst_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic [idst_pkg::SLOT_BITS-1:0]       rsp_slot,
   output logic [idst_pkg::ID_BITS-1:0]         rsp_record_id,
   output logic                                 rsp_table_empty
);
   import idst_pkg::*;

   logic [ID_BITS-1:0]     id_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] occ_ff, occ_in;

   logic [CNT_BITS-1:0]  entries_ff;
   logic [CNT_BITS-1:0]  used_n;
   cmd_type              op_ff;
   logic [ID_BITS-1:0]   key_ff;
   logic [CNT_BITS-1:0]  addr_ff;
   logic                 issue;

   logic                 rd_vld_ff;
   logic [SLOT_BITS-1:0] rd_idx_ff;
   logic                 rd_occ_ff;
   logic [ID_BITS-1:0]   rd_id_ff;

   logic                 free_found_ff;
   logic [SLOT_BITS-1:0] free_slot_ff;
   logic [ID_BITS-1:0]   max_id_ff;
   logic                 hit_found_ff;
   logic [SLOT_BITS-1:0] hit_slot_ff;
   logic [CNT_BITS-1:0]  occ_cnt_ff;

   logic                 rsp_valid_ff;
   status_type           res_status_ff, res_status;
   logic [SLOT_BITS-1:0] res_slot_ff, res_slot;
   logic [ID_BITS-1:0]   res_id_ff, res_id;
   logic                 res_empty_ff, res_empty;
   logic                 ins_ok;
   logic                 rmv_ok;
   logic [ID_BITS-1:0]   next_id;

   // register above the table size saturates
   assign used_n = (entries_ff > DEPTH_CNT) ? DEPTH_CNT : entries_ff;
   assign issue  = ctrl.scan && (addr_ff < used_n);
   assign next_id = max_id_ff + ID_ONE;

   assign stat.scan_last = (addr_ff >= used_n);
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= DEPTH_CNT;
      end else if (csr_wr_en) begin
         entries_ff <= csr_wr_data;
      end
   end

   // scan address and registered read of the id store
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         addr_ff   <= '0;
      end else begin
         rd_vld_ff <= issue;
         if (ctrl.start) begin
            addr_ff <= '0;
         end else if (issue) begin
            addr_ff <= addr_ff + CNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_id_ff  <= id_mem[addr_ff[SLOT_BITS-1:0]];
         rd_occ_ff <= occ_ff[addr_ff[SLOT_BITS-1:0]];
         rd_idx_ff <= addr_ff[SLOT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit && ins_ok) begin
         id_mem[free_slot_ff] <= next_id;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         op_ff <= cmd_type'(req_cmd);
         key_ff <= req_id;
      end
   end

   // search accumulators
   always_ff @(posedge clock) begin
      if (reset || ctrl.start) begin
         free_found_ff <= 1'b0;
         free_slot_ff  <= '0;
         max_id_ff     <= '0;
         hit_found_ff  <= 1'b0;
         hit_slot_ff   <= '0;
         occ_cnt_ff    <= '0;
      end else if (rd_vld_ff) begin
         if (rd_occ_ff) begin
            occ_cnt_ff <= occ_cnt_ff + CNT_BITS'(1);
            if (rd_id_ff > max_id_ff) begin
               max_id_ff <= rd_id_ff;
            end
            if (!hit_found_ff && (rd_id_ff == key_ff)) begin
               hit_found_ff <= 1'b1;
               hit_slot_ff  <= rd_idx_ff;
            end
         end else if (!free_found_ff) begin
            free_found_ff <= 1'b1;
            free_slot_ff  <= rd_idx_ff;
         end
      end
   end

   assign ins_ok = (op_ff == CMD_INSERT) && free_found_ff && (max_id_ff != ID_MAX);
   assign rmv_ok = (op_ff == CMD_REMOVE) && hit_found_ff;

   always_comb begin
      res_status = ST_OK;
      res_slot   = '0;
      res_id     = '0;
      res_empty  = (occ_cnt_ff == '0);
      unique case (op_ff)
         CMD_CLEAR: begin
            res_empty = 1'b1;
         end
         CMD_INSERT: begin
            if (!free_found_ff) begin
               res_status = ST_FULL;
            end else if (max_id_ff == ID_MAX) begin
               res_status = ST_EXHAUSTED;
            end else begin
               res_slot  = free_slot_ff;
               res_id    = next_id;
               res_empty = 1'b0;
            end
         end
         CMD_REMOVE, CMD_FIND: begin
            if (hit_found_ff) begin
               res_slot = hit_slot_ff;
               res_id   = key_ff;
               // after a remove the table is empty if the hit was the only one
               res_empty = (op_ff == CMD_REMOVE) ? (occ_cnt_ff == CNT_BITS'(1)) : 1'b0;
            end else begin
               res_status = ST_NOT_FOUND;
            end
         end
         default: begin
            res_status = ST_OK;
         end
      endcase
   end

   always_comb begin
      occ_in = occ_ff;
      if (ctrl.commit) begin
         if (op_ff == CMD_CLEAR) begin
            occ_in = '0;
         end else if (ins_ok) begin
            occ_in[free_slot_ff] = 1'b1;
         end else if (rmv_ok) begin
            occ_in[hit_slot_ff] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         res_status_ff <= res_status;
         res_slot_ff   <= res_slot;
         res_id_ff     <= res_id;
         res_empty_ff  <= res_empty;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = res_status_ff;
   assign rsp_slot        = res_slot_ff;
   assign rsp_record_id   = res_id_ff;
   assign rsp_table_empty = res_empty_ff;

endmodule

### src/id_record_slot_table.sv
// ----------------------------------------------------------------------------
// id_record_slot_table
// slot table with lowest-free-slot allocation and ascending record ids
// ----------------------------------------------------------------------------
// One command word is taken at a time. Every command (clear, insert, remove,
// find) scans the slots in use one per cycle through the single read port of
// the id store: the word is accepted, entries_in_use slots are read, the last
// read is folded in, and the commit writes the table update. The result word
// is registered at commit, which waits while an older word is held under
// rsp_stall, and may wait there under rsp_stall while the next command is
// taken. entries_in_use must be written through csr_wr_en / csr_wr_data only
// while the block is idle; the block itself does not enforce this.
module id_record_slot_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [idst_pkg::CNT_BITS-1:0]     csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [idst_pkg::CMD_BITS-1:0]     req_cmd,
   input  logic [idst_pkg::ID_BITS-1:0]      req_id,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [idst_pkg::STATUS_BITS-1:0]  rsp_status,
   output logic [idst_pkg::SLOT_BITS-1:0]    rsp_slot,
   output logic [idst_pkg::ID_BITS-1:0]      rsp_record_id,
   output logic                              rsp_table_empty
);
   import idst_pkg::*;

   ctl_cmd_type  ctrl;
   ctl_stat_type stat;

   idst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   idst_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_cmd         (req_cmd),
      .req_id          (req_id),
      .ctrl            (ctrl),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_record_id   (rsp_record_id),
      .rsp_table_empty (rsp_table_empty)
   );

endmodule

### src/idst_checker.sv
// ----------------------------------------------------------------------------
// idst_checker
// port-level checks for the slot table, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module idst_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [idst_pkg::STATUS_BITS-1:0]  rsp_status,
   input logic [idst_pkg::SLOT_BITS-1:0]    rsp_slot,
   input logic [idst_pkg::ID_BITS-1:0]      rsp_record_id,
   input logic                              rsp_table_empty
);
   import idst_pkg::*;

   // a held result word stays up
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result word dropped while stalled")

   // only one word in flight on the request side
   `ASSERT_NEXT(a_req_busy, clock, reset, req_valid && !req_stall, req_stall, "request taken during a scan")

   // failed commands carry no slot and no id
   `ASSERT_CLKD(a_fail_zero, clock, reset, rsp_valid && (rsp_status != ST_OK) |-> (rsp_slot == '0) && (rsp_record_id == '0), "nonzero fields on failed command")

   // exhausted id space means some slot holds the top id
   `ASSERT_CLKD(a_exh_occ, clock, reset, rsp_valid && (rsp_status == ST_EXHAUSTED) |-> !rsp_table_empty, "id space exhausted on empty table")

endmodule

bind id_record_slot_table idst_checker u_idst_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_slot        (rsp_slot),
   .rsp_record_id   (rsp_record_id),
   .rsp_table_empty (rsp_table_empty)
);
